>>> sv/tipa_pkg.sv
`timescale 1ns / 1ps
// Package for the temporal IIR pixel amplifier.
// Holds request types, filter taps, gain reset values and saturation helpers.
// No dependencies.
package tipa_pkg;

  localparam int PosW     = 14;
  localparam int LevelW   = 3;
  localparam int DataW    = 16;
  localparam int GainW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int NumGains = 8;
  localparam int Levels   = 8;
  localparam int WarmFrames = 4;
  localparam int DefaultFramePositions = 16384;

  localparam int AccW    = 34;
  localparam int GainPW  = 33;
  localparam int SatW    = 36;
  localparam int YFrac   = 14;
  localparam int GFrac   = 8;

  localparam logic signed [16:0] TapY2 = 17'sd18727;
  localparam logic signed [16:0] TapY4 = 17'sd6763;
  localparam logic signed [16:0] TapX0 = 17'sd10468;
  localparam logic signed [16:0] TapX2 = 17'sd20937;
  localparam logic signed [16:0] TapX4 = 17'sd10468;

  localparam logic signed [AccW-1:0]   RoundY = AccW'(1) <<< (YFrac - 1);
  localparam logic signed [GainPW-1:0] RoundG = GainPW'(1) <<< (GFrac - 1);

  localparam logic [1:0] SlotOpposite = 2'b10;

  localparam logic [NumGains-1:0][GainW-1:0] GainReset = {
    16'd1280, 16'd1280, 16'd1280, 16'd1280, 16'd1280, 16'd1280, 16'd0, 16'd0
  };

  localparam logic signed [SatW-1:0] SatMax = 36'sd32767;
  localparam logic signed [SatW-1:0] SatMin = -36'sd32768;

  typedef struct packed {
    logic [PosW-1:0]          position;
    logic [LevelW-1:0]        level;
    logic signed [DataW-1:0]  coefficient;
    logic                     end_of_frame;
  } tipa_in_t;

  typedef struct packed {
    logic signed [DataW-1:0]  amplified;
    logic signed [DataW-1:0]  filtered;
    logic                     warming_up;
  } tipa_out_t;

  function automatic logic signed [DataW-1:0] sat16(input logic signed [SatW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > SatMax) begin
      r = 16'sh7fff;
    end else if (v < SatMin) begin
      r = -16'sh8000;
    end else begin
      r = DataW'(v);
    end
    return r;
  endfunction

endpackage

>>> sv/tipa_hist_mem.sv
`timescale 1ns / 1ps
// History store: one write port and two registered read ports.
// Holds past coefficients and filter outputs; no package dependency.
module tipa_hist_mem #(
  parameter int AddrW = 18,
  parameter int DataW = 32,
  parameter int Depth = 65536
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr0_i,
  input  logic [AddrW-1:0] rd_addr1_i,
  output logic [DataW-1:0] rd_data0_o,
  output logic [DataW-1:0] rd_data1_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data0_q, rd_data1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data0_q <= mem_q[rd_addr0_i];
      rd_data1_q <= mem_q[rd_addr1_i];
    end
  end

  assign rd_data0_o = rd_data0_q;
  assign rd_data1_o = rd_data1_q;

endmodule

>>> sv/temporal_iir_pixel_amplifier_top.sv
`timescale 1ns / 1ps
// Top level of the temporal IIR pixel amplifier.
// Depends on tipa_pkg and tipa_hist_mem.
//
// Takes one coefficient request per cycle while not stalled and returns one
// result request per input, in order. Each request reads the history word of
// its own position two and four frames back from a dual-read history memory
// and writes its coefficient and filter output back from stage E. When a
// request reads an entry that one of the two requests just ahead of it will
// write (a repeated position, or a run of end-of-frame marks), it waits in the
// address stage until the value can be forwarded; otherwise, and while the
// output is not stalled, the rate is one per cycle.
// History entries are not cleared at reset, so the first four frames must
// cover every position used; results stay zero while warming_up is set.
module temporal_iir_pixel_amplifier_top #(
  parameter int FRAME_POSITIONS = tipa_pkg::DefaultFramePositions
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tipa_pkg::tipa_in_t                  in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tipa_pkg::tipa_out_t                 out_req_o,
  input  logic                                cfg_we_i,
  input  logic [tipa_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tipa_pkg::GainW-1:0]          cfg_wdata_i
);

  localparam int PosW     = tipa_pkg::PosW;
  localparam int DataW    = tipa_pkg::DataW;
  localparam int LevelW   = tipa_pkg::LevelW;
  localparam int AccW     = tipa_pkg::AccW;
  localparam int GainPW   = tipa_pkg::GainPW;
  localparam int SatW     = tipa_pkg::SatW;
  localparam int RowW     = $clog2(FRAME_POSITIONS);
  localparam int AddrW    = RowW + 2;
  localparam int MemDepth = 4 * FRAME_POSITIONS;
  localparam int HistW    = 2 * DataW;

  // configuration
  logic [tipa_pkg::NumGains-1:0][tipa_pkg::GainW-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= tipa_pkg::GainReset;
    end else if (cfg_we_i) begin
      gain_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // handshake and flow control
  logic adv, hazard, move_a, in_accept;
  logic out_valid_q;
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, e_valid_q, f_valid_q, rec_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign move_a     = a_valid_q && adv && !hazard;
  assign in_stall_o = a_valid_q && !move_a;
  assign in_accept  = in_valid_i && !in_stall_o;

  // frame state
  logic [2:0] frames_seen_q;
  logic [1:0] frame_slot_q;
  logic       warm_in;

  assign warm_in = frames_seen_q < 3'(tipa_pkg::WarmFrames);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_seen_q <= '0;
      frame_slot_q  <= '0;
    end else if (in_accept && in_req_i.end_of_frame) begin
      frame_slot_q <= frame_slot_q + 2'd1;
      if (warm_in) begin
        frames_seen_q <= frames_seen_q + 3'd1;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      rec_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        a_valid_q <= 1'b1;
      end else if (move_a) begin
        a_valid_q <= 1'b0;
      end
      if (adv) begin
        b_valid_q   <= move_a;
        c_valid_q   <= b_valid_q;
        d_valid_q   <= c_valid_q;
        e_valid_q   <= d_valid_q;
        f_valid_q   <= e_valid_q;
        rec_valid_q <= e_valid_q;
        out_valid_q <= f_valid_q;
      end
    end
  end

  // stage A: accepted request, position wrap and history addresses
  logic [PosW-1:0]         a_pos_q;
  logic [LevelW-1:0]       a_level_q;
  logic signed [DataW-1:0] a_coef_q;
  logic [1:0]              a_slot_q;
  logic                    a_warm_q;
  logic [RowW-1:0]         a_row;
  logic [AddrW-1:0]        a_cur, a_two;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_pos_q   <= in_req_i.position;
      a_level_q <= in_req_i.level;
      a_coef_q  <= in_req_i.coefficient;
      a_slot_q  <= frame_slot_q;
      a_warm_q  <= warm_in;
    end
  end

  if (FRAME_POSITIONS < (1 << PosW)) begin : gen_wrap
    localparam int Shift  = PosW + RowW;
    localparam int RecipW = PosW + 2;
    localparam logic [63:0] Recip =
      ((64'd1 << Shift) + 64'(FRAME_POSITIONS) - 64'd1) / 64'(FRAME_POSITIONS);
    localparam logic [PosW-1:0] FpW = PosW'(FRAME_POSITIONS);

    logic [PosW+RecipW-1:0] prod;
    logic [PosW-1:0]        quot_d, quot_q, base;

    assign prod   = in_req_i.position * RecipW'(Recip);
    assign quot_d = PosW'(prod >> Shift);

    always_ff @(posedge clk_i) begin
      if (in_accept) begin
        quot_q <= quot_d;
      end
    end

    assign base  = quot_q * FpW;
    assign a_row = RowW'(a_pos_q - base);
  end else begin : gen_direct
    assign a_row = RowW'(a_pos_q);
  end

  assign a_cur = {a_row, a_slot_q};
  assign a_two = {a_row, a_slot_q ^ tipa_pkg::SlotOpposite};

  // stage registers
  logic [AddrW-1:0]        b_cur_q, b_two_q, c_cur_q, d_cur_q, e_cur_q, rec_addr_q;
  logic [LevelW-1:0]       b_level_q, c_level_q, d_level_q, e_level_q;
  logic signed [DataW-1:0] b_coef_q, c_coef_q, d_coef_q, e_coef_q, f_coef_q;
  logic                    b_warm_q, c_warm_q, d_warm_q, e_warm_q, f_warm_q;
  logic signed [31:0]      c_p_y2_q, c_p_y4_q, c_p_x0_q, c_p_x2_q, c_p_x4_q;
  logic signed [AccW-1:0]  d_acc_q;
  logic signed [DataW-1:0] e_y_q, f_y_q;
  logic signed [GainPW-1:0] f_gp_q;
  logic [HistW-1:0]        rec_data_q;
  tipa_pkg::tipa_out_t     out_req_q;

  // hold back a request whose entry is still being filtered ahead of it
  assign hazard = (b_valid_q && (b_cur_q == a_cur || b_cur_q == a_two)) ||
                  (c_valid_q && (c_cur_q == a_cur || c_cur_q == a_two));

  // history memory
  logic [HistW-1:0] rd_cur, rd_two, e_hist;

  assign e_hist = {e_coef_q, e_y_q};

  tipa_hist_mem #(
    .AddrW (AddrW),
    .DataW (HistW),
    .Depth (MemDepth)
  ) u_hist_mem (
    .clk_i      (clk_i),
    .wr_en_i    (adv && e_valid_q),
    .wr_addr_i  (e_cur_q),
    .wr_data_i  (e_hist),
    .rd_en_i    (move_a),
    .rd_addr0_i (a_cur),
    .rd_addr1_i (a_two),
    .rd_data0_o (rd_cur),
    .rd_data1_o (rd_two)
  );

  // stage B: forward pending writes, multiply by taps
  logic [HistW-1:0]        hist_cur, hist_two;
  logic signed [DataW-1:0] hx_cur, hy_cur, hx_two, hy_two;

  always_comb begin
    hist_cur = rd_cur;
    hist_two = rd_two;
    if (rec_valid_q && rec_addr_q == b_cur_q) begin
      hist_cur = rec_data_q;
    end
    if (rec_valid_q && rec_addr_q == b_two_q) begin
      hist_two = rec_data_q;
    end
    if (e_valid_q && e_cur_q == b_cur_q) begin
      hist_cur = e_hist;
    end
    if (e_valid_q && e_cur_q == b_two_q) begin
      hist_two = e_hist;
    end
  end

  assign hx_cur = $signed(hist_cur[HistW-1 -: DataW]);
  assign hy_cur = $signed(hist_cur[DataW-1:0]);
  assign hx_two = $signed(hist_two[HistW-1 -: DataW]);
  assign hy_two = $signed(hist_two[DataW-1:0]);

  // stage C: tap sum
  logic signed [AccW-1:0] c_acc;

  assign c_acc = AccW'(c_p_y2_q) - AccW'(c_p_y4_q) + AccW'(c_p_x0_q)
               - AccW'(c_p_x2_q) + AccW'(c_p_x4_q);

  // stage D: round and saturate the filter output, zero during warm-up
  logic signed [AccW-1:0]  d_rnd;
  logic signed [DataW-1:0] d_y;

  assign d_rnd = (d_acc_q + tipa_pkg::RoundY) >>> tipa_pkg::YFrac;
  assign d_y   = d_warm_q ? '0 : tipa_pkg::sat16(SatW'(d_rnd));

  // stage E: gain product
  logic [tipa_pkg::GainW-1:0] e_gain;
  logic signed [GainPW-1:0]   e_gp;

  assign e_gain = (4'(e_level_q) < 4'(tipa_pkg::Levels)) ? gain_q[e_level_q] : '0;
  assign e_gp   = $signed({1'b0, e_gain}) * e_y_q;

  // stage F: round the gain product, add to coefficient and saturate, zero during warm-up
  logic signed [GainPW-1:0] f_rnd;
  logic signed [SatW-1:0]   f_sum;
  logic signed [DataW-1:0]  f_amp;

  assign f_rnd = (f_gp_q + tipa_pkg::RoundG) >>> tipa_pkg::GFrac;
  assign f_sum = SatW'(f_rnd) + SatW'(f_coef_q);
  assign f_amp = f_warm_q ? '0 : tipa_pkg::sat16(f_sum);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_cur_q    <= a_cur;
      b_two_q    <= a_two;
      b_level_q  <= a_level_q;
      b_coef_q   <= a_coef_q;
      b_warm_q   <= a_warm_q;

      c_cur_q    <= b_cur_q;
      c_level_q  <= b_level_q;
      c_coef_q   <= b_coef_q;
      c_warm_q   <= b_warm_q;
      c_p_y2_q   <= hy_two * tipa_pkg::TapY2;
      c_p_y4_q   <= hy_cur * tipa_pkg::TapY4;
      c_p_x0_q   <= b_coef_q * tipa_pkg::TapX0;
      c_p_x2_q   <= hx_two * tipa_pkg::TapX2;
      c_p_x4_q   <= hx_cur * tipa_pkg::TapX4;

      d_cur_q    <= c_cur_q;
      d_level_q  <= c_level_q;
      d_coef_q   <= c_coef_q;
      d_warm_q   <= c_warm_q;
      d_acc_q    <= c_acc;

      e_cur_q    <= d_cur_q;
      e_level_q  <= d_level_q;
      e_coef_q   <= d_coef_q;
      e_warm_q   <= d_warm_q;
      e_y_q      <= d_y;

      rec_addr_q <= e_cur_q;
      rec_data_q <= e_hist;

      f_coef_q   <= e_coef_q;
      f_warm_q   <= e_warm_q;
      f_y_q      <= e_y_q;
      f_gp_q     <= e_gp;

      out_req_q.amplified  <= f_amp;
      out_req_q.filtered   <= f_y_q;
      out_req_q.warming_up <= f_warm_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

>>> sv/tipa_checker.sv
`timescale 1ns / 1ps
// Port checker for the temporal IIR pixel amplifier, bound to the top level.
// Depends on tipa_pkg and temporal_iir_pixel_amplifier_top.
module tipa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tipa_pkg::tipa_out_t out_req_o
);

  logic       in_acc, out_acc;
  logic [3:0] pending_q;
  logic       settled_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      settled_q <= 1'b0;
    end else begin
      pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
      if (out_acc && !out_req_o.warming_up) begin
        settled_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result request changed");

  a_warm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.warming_up |->
      out_req_o.amplified == '0 && out_req_o.filtered == '0)
    else $error("non-zero result during warm-up");

  a_warm_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && settled_q |-> !out_req_o.warming_up)
    else $error("warm-up flag returned after settling");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result request without an accepted input");

endmodule

bind temporal_iir_pixel_amplifier_top tipa_checker u_tipa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
